// ===== hdl/kalman_angle_bias_filter_unit_macros.svh =====
// Assertion macros for the angle/bias filter unit.
// Included by the top level only; no other dependencies.
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KABF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define KABF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KABF_ASSERT_SAME(label, clk, rst, ante, cons)
`define KABF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/kabf_pkg.sv =====
// Shared types, register indices and saturating arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps
package kabf_pkg;
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 31;
   localparam int DT_W      = 21;
   localparam int CSR_IDX_W = 2;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam csr_idx_type CSR_NOISE_ANGLE = 2'd0;
   localparam csr_idx_type CSR_NOISE_BIAS  = 2'd1;
   localparam csr_idx_type CSR_NOISE_MEAS  = 2'd2;

   function automatic word_type sat_wide(input logic signed [64:0] v);
      if (v > 65'sd2147483647) return 32'sh7fffffff;
      if (v < -65'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic word_type add_s(input word_type a, input word_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
      return s[31:0];
   endfunction

   function automatic word_type sub_s(input word_type a, input word_type b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
      return s[31:0];
   endfunction
endpackage

// ===== hdl/kabf_if.sv =====
// Channel interfaces: sample input, estimate output and register write.
// Depends on kabf_pkg.
`timescale 1ns / 1ps
interface kabf_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [31:0]          measured_angle;
   logic signed [31:0]          gyro_rate;
   logic [kabf_pkg::DT_W-1:0]   time_step;
   modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
   modport sink   (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kabf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_estimate;
   logic signed [31:0] bias_estimate;
   modport source (output valid, angle_estimate, bias_estimate, input ready);
   modport sink   (input valid, angle_estimate, bias_estimate, output ready);
endinterface

interface kabf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [kabf_pkg::CSR_IDX_W-1:0] index;
   logic [kabf_pkg::CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/kabf_mul.sv =====
// Bit-serial signed fixed-point multiplier: shift-add on magnitudes, one bit per cycle,
// then sign, floor shift and saturation. Depends on kabf_pkg.
`timescale 1ns / 1ps
module kabf_mul #(
   parameter int FRAC_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  kabf_pkg::word_type op_a,
   input  kabf_pkg::word_type op_b,
   output logic               busy,
   output logic               done,
   output kabf_pkg::word_type result
);
   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_type;

   state_type          state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        amag_ff, amag_in;
   logic [31:0]        hi_ff, hi_in;
   logic [31:0]        lo_ff, lo_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   kabf_pkg::word_type res_ff, res_in;
   logic [32:0]        sum;
   logic signed [64:0] prod;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      amag_in  = amag_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, amag_ff} : 33'd0);
      prod     = neg_ff ? -$signed({1'b0, hi_ff, lo_ff}) : $signed({1'b0, hi_ff, lo_ff});
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               amag_in  = op_a[31] ? 32'(-op_a) : op_a;
               lo_in    = op_b[31] ? 32'(-op_b) : op_b;
               hi_in    = '0;
               neg_in   = op_a[31] ^ op_b[31];
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            hi_in  = sum[32:1];
            lo_in  = {sum[0], lo_ff[31:1]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = ST_FIN;
         end
         ST_FIN: begin
            // arithmetic shift floors, as required for negative products
            res_in   = kabf_pkg::sat_wide(prod >>> FRAC_BITS);
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      amag_ff <= amag_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign done   = done_ff;
   assign result = res_ff;
endmodule

// ===== hdl/kabf_div.sv =====
// Bit-serial restoring divider for the gains: (n * 2^FRAC_BITS) / d, floored, saturated,
// zero for a zero divisor. One quotient bit per cycle. Depends on kabf_pkg.
`timescale 1ns / 1ps
module kabf_div #(
   parameter int FRAC_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  kabf_pkg::word_type numer,
   input  kabf_pkg::word_type denom,
   output logic               busy,
   output logic               done,
   output kabf_pkg::word_type result
);
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   nq_ff, nq_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic               done_ff, done_in;
   kabf_pkg::word_type res_ff, res_in;
   logic [32:0]        trial;
   logic [32:0]        diff;
   logic               ge;
   logic signed [64:0] qv;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      nq_in    = nq_ff;
      rem_in   = rem_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      trial    = {rem_ff, nq_ff[NUM_W-1]};
      diff     = trial - {1'b0, dmag_ff};
      ge       = (trial >= {1'b0, dmag_ff});
      qv       = $signed({{(65-NUM_W){1'b0}}, nq_ff});
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               nq_in    = {(numer[31] ? 32'(-numer) : numer), {FRAC_BITS{1'b0}}};
               dmag_in  = denom[31] ? 32'(-denom) : denom;
               neg_in   = numer[31] ^ denom[31];
               zero_in  = (denom == '0);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rem_in = ge ? diff[31:0] : trial[31:0];
            nq_in  = {nq_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            // opposite signs with a remainder round one further down
            if (zero_ff) res_in = '0;
            else if (neg_ff) res_in = kabf_pkg::sat_wide(-(qv + 65'(rem_ff != '0)));
            else res_in = kabf_pkg::sat_wide(qv);
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      nq_ff   <= nq_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      res_ff  <= res_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign done   = done_ff;
   assign result = res_ff;
endmodule

// ===== hdl/kalman_angle_bias_filter_unit.sv =====
// Channel   | direction | carries
// req_chan  | in        | measured_angle, gyro_rate, time_step
// rsp_chan  | out       | angle_estimate, bias_estimate
// csr_chan  | in        | index, data (noise registers, always ready)
//
// Each sample runs ten products through the bit-serial multiplier and two gains
// through the serial divider.
// Synchronous reset clears the state and covariance and loads the noise defaults.
// A new sample is taken while the previous estimate waits in the output register.
// If that estimate is still unread when the next is ready, the unit holds until it transfers.
// Depends on kabf_pkg, kabf_if, kabf_mul, kabf_div and the macros header.
`timescale 1ns / 1ps
`include "kalman_angle_bias_filter_unit_macros.svh"
module kalman_angle_bias_filter_unit #(
   parameter int FRAC_BITS = 20
) (
   input logic        clock,
   input logic        reset,
   kabf_req_if.sink   req_chan,
   kabf_rsp_if.source rsp_chan,
   kabf_csr_if.sink   csr_chan
);
   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam logic [30:0] QA_RESET = 31'((ONE + 500) / 1000);
   localparam logic [30:0] QB_RESET = 31'((3 * ONE + 500) / 1000);
   localparam logic [30:0] R_RESET  = 31'((3 * ONE + 50) / 100);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_type;
   typedef enum logic [4:0] {
      SP_T0, SP_PRA, SP_DP, SP_T2, SP_T3, SP_PAA, SP_POFF, SP_PBB, SP_S,
      SP_K0, SP_K1, SP_Y, SP_CA, SP_CB, SP_U10, SP_U11, SP_U00, SP_U01
   } step_type;

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   logic               wait_ff, wait_in;
   logic [30:0]        qa_ff, qb_ff, r_ff;
   kabf_pkg::word_type angle_ff, angle_in, bias_ff, bias_in;
   kabf_pkg::word_type paa_ff, paa_in, pab_ff, pab_in, pba_ff, pba_in, pbb_ff, pbb_in;
   kabf_pkg::word_type meas_ff, meas_in, rate_ff, rate_in;
   logic [20:0]        dt_ff, dt_in;
   kabf_pkg::word_type tmp_ff, tmp_in, dp_ff, dp_in, s_ff, s_in, k0_ff, k0_in, k1_ff, k1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kabf_pkg::word_type out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [4:0]         step_nx;
   logic               advance;
   logic               req_xfer;
   logic               run_entry;

   logic               mul_start, mul_busy, mul_done;
   kabf_pkg::word_type mul_a, mul_b, mul_res;
   logic               div_start, div_busy, div_done;
   kabf_pkg::word_type div_n, div_d, div_res;
   kabf_pkg::word_type dt_w;

   assign dt_w = {11'd0, dt_ff};

   kabf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .busy(mul_busy), .done(mul_done), .result(mul_res)
   );

   kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_n), .denom(div_d),
      .busy(div_busy), .done(div_done), .result(div_res)
   );

   // unit operands per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = paa_ff;
      div_d = s_ff;
      case (step_ff)
         SP_PRA: begin mul_a = dt_w;  mul_b = tmp_ff; end
         SP_DP:  begin mul_a = dt_w;  mul_b = pbb_ff; end
         SP_PAA: begin mul_a = dt_w;  mul_b = tmp_ff; end
         SP_PBB: begin mul_a = {1'b0, qb_ff}; mul_b = dt_w; end
         SP_K1:  div_n = pba_ff;
         SP_CA:  begin mul_a = k0_ff; mul_b = tmp_ff; end
         SP_CB:  begin mul_a = k1_ff; mul_b = tmp_ff; end
         SP_U10: begin mul_a = k1_ff; mul_b = paa_ff; end
         SP_U11: begin mul_a = k1_ff; mul_b = pab_ff; end
         SP_U00: begin mul_a = k0_ff; mul_b = paa_ff; end
         SP_U01: begin mul_a = k0_ff; mul_b = pab_ff; end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      wait_in      = wait_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      paa_in       = paa_ff;
      pab_in       = pab_ff;
      pba_in       = pba_ff;
      pbb_in       = pbb_ff;
      meas_in      = meas_ff;
      rate_in      = rate_ff;
      dt_in        = dt_ff;
      tmp_in       = tmp_ff;
      dp_in        = dp_ff;
      s_in         = s_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      advance      = 1'b0;
      step_nx      = 5'(step_ff) + 5'd1;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               meas_in  = req_chan.measured_angle;
               rate_in  = req_chan.gyro_rate;
               dt_in    = req_chan.time_step;
               step_in  = SP_T0;
               wait_in  = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            case (step_ff)
               SP_T0: begin
                  tmp_in  = kabf_pkg::sub_s(rate_ff, bias_ff);
                  advance = 1'b1;
               end
               SP_T2: begin
                  tmp_in  = kabf_pkg::sub_s(tmp_ff, pba_ff);
                  advance = 1'b1;
               end
               SP_T3: begin
                  tmp_in  = kabf_pkg::add_s(tmp_ff, {1'b0, qa_ff});
                  advance = 1'b1;
               end
               SP_POFF: begin
                  pab_in  = kabf_pkg::sub_s(pab_ff, dp_ff);
                  pba_in  = kabf_pkg::sub_s(pba_ff, dp_ff);
                  advance = 1'b1;
               end
               SP_S: begin
                  s_in    = kabf_pkg::add_s(paa_ff, {1'b0, r_ff});
                  advance = 1'b1;
               end
               SP_Y: begin
                  tmp_in  = kabf_pkg::sub_s(meas_ff, angle_ff);
                  advance = 1'b1;
               end
               SP_K0, SP_K1: begin
                  if (!wait_ff) begin
                     div_start = 1'b1;
                     wait_in   = 1'b1;
                  end else if (div_done) begin
                     if (step_ff == SP_K0) k0_in = div_res;
                     else k1_in = div_res;
                     wait_in = 1'b0;
                     advance = 1'b1;
                  end
               end
               default: begin
                  if (!wait_ff) begin
                     mul_start = 1'b1;
                     wait_in   = 1'b1;
                  end else if (mul_done) begin
                     wait_in = 1'b0;
                     advance = 1'b1;
                     case (step_ff)
                        SP_PRA: angle_in = kabf_pkg::add_s(angle_ff, mul_res);
                        SP_DP: begin
                           dp_in  = mul_res;
                           tmp_in = kabf_pkg::sub_s(mul_res, pab_ff);
                        end
                        SP_PAA: paa_in  = kabf_pkg::add_s(paa_ff, mul_res);
                        SP_PBB: pbb_in  = kabf_pkg::add_s(pbb_ff, mul_res);
                        SP_CA:  angle_in = kabf_pkg::add_s(angle_ff, mul_res);
                        SP_CB:  bias_in = kabf_pkg::add_s(bias_ff, mul_res);
                        SP_U10: pba_in  = kabf_pkg::sub_s(pba_ff, mul_res);
                        SP_U11: pbb_in  = kabf_pkg::sub_s(pbb_ff, mul_res);
                        SP_U00: paa_in  = kabf_pkg::sub_s(paa_ff, mul_res);
                        SP_U01: pab_in  = kabf_pkg::sub_s(pab_ff, mul_res);
                        default: ;
                     endcase
                  end
               end
            endcase
            if (advance) begin
               if (step_ff == SP_U01) state_in = ST_OUT;
               else step_in = step_type'(step_nx);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_a_in     = angle_ff;
               out_b_in     = bias_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_T0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         paa_ff       <= '0;
         pab_ff       <= '0;
         pba_ff       <= '0;
         pbb_ff       <= '0;
         qa_ff        <= QA_RESET;
         qb_ff        <= QB_RESET;
         r_ff         <= R_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         paa_ff       <= paa_in;
         pab_ff       <= pab_in;
         pba_ff       <= pba_in;
         pbb_ff       <= pbb_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               kabf_pkg::CSR_NOISE_ANGLE: qa_ff <= csr_chan.data;
               kabf_pkg::CSR_NOISE_BIAS:  qb_ff <= csr_chan.data;
               kabf_pkg::CSR_NOISE_MEAS:  r_ff  <= csr_chan.data;
               default: ;
            endcase
         end
      end
      meas_ff  <= meas_in;
      rate_ff  <= rate_in;
      dt_ff    <= dt_in;
      tmp_ff   <= tmp_in;
      dp_ff    <= dp_in;
      s_ff     <= s_in;
      k0_ff    <= k0_in;
      k1_ff    <= k1_in;
      out_a_ff <= out_a_in;
      out_b_ff <= out_b_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.angle_estimate = out_a_ff;
   assign rsp_chan.bias_estimate  = out_b_ff;

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign run_entry = (state_ff == ST_RUN) && (step_ff == SP_T0);

   `KABF_ASSERT_SAME(a_mul_idle_on_start, clock, reset, mul_start, !mul_busy)
   `KABF_ASSERT_SAME(a_div_idle_on_start, clock, reset, div_start, !div_busy)
   `KABF_ASSERT_NEXT(a_sample_starts_run, clock, reset, req_xfer, run_entry)
   `KABF_ASSERT_SAME(a_single_unit_busy, clock, reset, mul_busy, !div_busy)
endmodule
